[hdl/pfsa_pkg.sv]
// ----------------------------------------------------------------------------
// pfsa_pkg
// Shared types, codes and sizes of the page frame stack allocator.
// ----------------------------------------------------------------------------
package pfsa_pkg;

  localparam int MAX_FRAMES = 65536;
  localparam int DMA_FRAMES = 32;

  localparam int FRAME_W  = 20;
  localparam int CNT_W    = 17;
  localparam int IDX_W    = $clog2(MAX_FRAMES);
  localparam int PAGES_W  = 6;
  localparam int DMA_W    = PAGES_W + 1;
  localparam int STATUS_W = 3;
  localparam int KIND_W   = 2;
  localparam int CFG_IDX_W = 3;

  localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DMA   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY       = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OUTSIDE     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_ALLOC   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL        = 3'd4;
  localparam logic [STATUS_W-1:0] ST_ALREADY     = 3'd5;
  localparam logic [STATUS_W-1:0] ST_DMA_REFUSED = 3'd6;

  localparam logic [CFG_IDX_W-1:0] CFG_MAP_FIRST  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_FRAMES = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_FIRST = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_FRAMES = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DMA_FIRST  = 3'd4;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [FRAME_W-1:0] frame;
    logic [PAGES_W-1:0] dma_pages;
  } request_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FRAME_W-1:0]  frame_out;
    logic [CNT_W-1:0]    allocated_count;
  } result_t;

  typedef struct packed {
    logic accept;
    logic clear;
    logic stack_rd;
    logic map_rd;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic out_busy;
  } sts_t;

endpackage

[hdl/pfsa_ctrl.sv]
// ----------------------------------------------------------------------------
// pfsa_ctrl
// Sequencer: bitmap clearing pass, then stack lookup (allocate only), map lookup and commit.
// ----------------------------------------------------------------------------
module pfsa_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    request_valid,
  input  logic [pfsa_pkg::KIND_W-1:0] request_kind,
  output logic                    request_stall,
  output pfsa_pkg::cmd_t          cmd,
  input  pfsa_pkg::sts_t          sts
);
  import pfsa_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_STACK,
    S_MAP,
    S_DECIDE
  } state_t;

  state_t state;
  logic   can_take;

  assign can_take = (state == S_IDLE) || ((state == S_DECIDE) && !sts.out_busy);
  assign request_stall = !can_take;

  assign cmd.accept   = can_take && request_valid;
  assign cmd.clear    = (state == S_CLEAR);
  assign cmd.stack_rd = (state == S_STACK);
  assign cmd.map_rd   = (state == S_MAP);
  assign cmd.commit   = (state == S_DECIDE) && !sts.out_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      unique case (state)
        S_CLEAR: begin
          if (sts.clear_done) state <= S_IDLE;
        end
        S_IDLE, S_DECIDE: begin
          if (cmd.accept) begin
            state <= (request_kind == KIND_ALLOC) ? S_STACK : S_MAP;
          end else if (cmd.commit) begin
            state <= S_IDLE;
          end
        end
        S_STACK: state <= S_MAP;
        S_MAP:   state <= S_DECIDE;
        default: state <= S_CLEAR;
      endcase
    end
  end

endmodule

[hdl/pfsa_dp.sv]
// ----------------------------------------------------------------------------
// pfsa_dp
// Datapath: settings, free frame stack, allocated bitmap, counters, result.
// ----------------------------------------------------------------------------
module pfsa_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [pfsa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pfsa_pkg::FRAME_W-1:0]  cfg_data,
  input  pfsa_pkg::request_t            request,
  output logic                          result_valid,
  input  logic                          result_stall,
  output pfsa_pkg::result_t             result,
  input  pfsa_pkg::cmd_t                cmd,
  output pfsa_pkg::sts_t                sts
);
  import pfsa_pkg::*;

  localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_FRAMES);
  localparam logic [DMA_W-1:0] DMA_C = DMA_W'(DMA_FRAMES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_FRAMES - 1);

  logic [FRAME_W-1:0] map_first_frame;
  logic [CNT_W-1:0]   map_frames;
  logic [FRAME_W-1:0] pool_first_frame;
  logic [CNT_W-1:0]   pool_frames;
  logic [FRAME_W-1:0] dma_first_frame;

  logic [CNT_W-1:0]   net_taken;
  logic [CNT_W-1:0]   deepest_taken;
  logic [PAGES_W-1:0] dma_used;
  logic [IDX_W-1:0]   clr_addr;

  logic [FRAME_W-1:0] stack_mem [MAX_FRAMES];
  logic               bitmap [MAX_FRAMES];

  request_t           req;
  logic [FRAME_W-1:0] stk_q;
  logic               bit_q;
  logic               lazy;
  logic [FRAME_W-1:0] lazy_frame;
  logic [FRAME_W-1:0] cand_frame;
  logic               cand_in_map;
  logic [IDX_W-1:0]   cand_idx;

  logic [CNT_W-1:0]   cap;
  logic [CNT_W-1:0]   win;
  logic [CNT_W-1:0]   depth;
  logic [CNT_W-1:0]   lazy_bound;
  logic [CNT_W-1:0]   top_pos;
  logic [FRAME_W-1:0] f;
  logic [FRAME_W-1:0] off;
  logic               in_map;
  logic [DMA_W-1:0]   room;

  logic [STATUS_W-1:0] status;
  logic [FRAME_W-1:0]  given;
  logic [CNT_W-1:0]    net_next;
  logic [PAGES_W-1:0]  dma_used_next;
  logic                bm_set;
  logic                bm_clr;
  logic                stk_we;
  logic                bm_we;
  logic [IDX_W-1:0]    bm_waddr;
  logic                bm_wdata;

  assign cap        = (pool_frames > MAX_C) ? MAX_C : pool_frames;
  assign win        = (map_frames > MAX_C) ? MAX_C : map_frames;
  assign depth      = (net_taken <= cap) ? cap - net_taken : '0;
  assign lazy_bound = (deepest_taken <= cap) ? cap - deepest_taken : '0;
  assign top_pos    = depth - CNT_W'(1);
  assign room       = ({1'b0, dma_used} <= DMA_C) ? DMA_C - {1'b0, dma_used} : '0;

  always_comb begin
    unique case (req.kind)
      KIND_ALLOC: f = lazy ? lazy_frame : stk_q;
      KIND_FREE:  f = req.frame;
      default:    f = dma_first_frame + FRAME_W'(dma_used);
    endcase
  end

  assign off    = f - map_first_frame;
  assign in_map = (f >= map_first_frame) && (off < FRAME_W'(win));

  always_comb begin
    status        = ST_OK;
    given         = '0;
    net_next      = net_taken;
    dma_used_next = dma_used;
    bm_set        = 1'b0;
    bm_clr        = 1'b0;
    stk_we        = 1'b0;
    unique case (req.kind)
      KIND_ALLOC: begin
        if (depth == '0) begin
          status = ST_EMPTY;
        end else begin
          net_next = net_taken + CNT_W'(1);
          if (!cand_in_map) begin
            status = ST_OUTSIDE;
          end else if (bit_q) begin
            status = ST_ALREADY;
          end else begin
            bm_set = 1'b1;
            given  = cand_frame;
          end
        end
      end
      KIND_FREE: begin
        if (depth >= cap) begin
          status = ST_FULL;
        end else if (!cand_in_map) begin
          status = ST_OUTSIDE;
        end else if (!bit_q) begin
          status = ST_NOT_ALLOC;
        end else begin
          bm_clr   = 1'b1;
          stk_we   = 1'b1;
          net_next = net_taken - CNT_W'(1);
        end
      end
      KIND_DMA: begin
        if (req.dma_pages == '0 || {1'b0, req.dma_pages} > room) begin
          status = ST_DMA_REFUSED;
        end else if (!cand_in_map) begin
          status = ST_OUTSIDE;
        end else if (bit_q) begin
          status = ST_ALREADY;
        end else begin
          bm_set        = 1'b1;
          dma_used_next = dma_used + req.dma_pages;
          given         = cand_frame;
        end
      end
      default: begin
      end
    endcase
  end

  assign bm_we    = cmd.clear || (cmd.commit && (bm_set || bm_clr));
  assign bm_waddr = cmd.clear ? clr_addr : cand_idx;
  assign bm_wdata = !cmd.clear && bm_set;

  always_ff @(posedge clk) begin
    if (bm_we) bitmap[bm_waddr] <= bm_wdata;
    bit_q <= bitmap[off[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && stk_we) stack_mem[depth[IDX_W-1:0]] <= req.frame;
    stk_q <= stack_mem[top_pos[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) req <= request;
    if (cmd.stack_rd) begin
      lazy       <= top_pos < lazy_bound;
      lazy_frame <= pool_first_frame + FRAME_W'(top_pos);
    end
    if (cmd.map_rd) begin
      cand_frame  <= f;
      cand_in_map <= in_map;
      cand_idx    <= off[IDX_W-1:0];
    end
    if (cmd.commit) begin
      result.status          <= status;
      result.frame_out       <= given;
      result.allocated_count <= net_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      map_first_frame  <= '0;
      map_frames       <= MAX_C;
      pool_first_frame <= '0;
      pool_frames      <= '0;
      dma_first_frame  <= '0;
      net_taken        <= '0;
      deepest_taken    <= '0;
      dma_used         <= '0;
      clr_addr         <= '0;
      result_valid     <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_MAP_FIRST:   map_first_frame  <= cfg_data;
          CFG_MAP_FRAMES:  map_frames       <= cfg_data[CNT_W-1:0];
          CFG_POOL_FIRST:  pool_first_frame <= cfg_data;
          CFG_POOL_FRAMES: pool_frames      <= cfg_data[CNT_W-1:0];
          CFG_DMA_FIRST:   dma_first_frame  <= cfg_data;
          default: begin
          end
        endcase
      end
      if (cmd.clear) clr_addr <= clr_addr + IDX_W'(1);
      if (cmd.commit) begin
        net_taken <= net_next;
        dma_used  <= dma_used_next;
        if (net_next > deepest_taken) deepest_taken <= net_next;
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  assign sts.clear_done = (clr_addr == LAST_IDX);
  assign sts.out_busy   = result_valid && result_stall;

endmodule

[hdl/page_frame_stack_allocator.sv]
// ----------------------------------------------------------------------------
// page_frame_stack_allocator: an allocate result is registered after a stack
// read, then a bitmap read; free and DMA results after a bitmap read alone.
// Next item is taken only as the last result is registered; a stalled output holds both.
// Reset runs a bitmap clearing pass over all 65536 entries; no item taken until done.
// ----------------------------------------------------------------------------
module page_frame_stack_allocator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [pfsa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pfsa_pkg::FRAME_W-1:0]  cfg_data,
  input  logic                          request_valid,
  output logic                          request_stall,
  input  pfsa_pkg::request_t            request,
  output logic                          result_valid,
  input  logic                          result_stall,
  output pfsa_pkg::result_t             result
);
  import pfsa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  pfsa_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .request_valid (request_valid),
    .request_kind  (request.kind),
    .request_stall (request_stall),
    .cmd           (cmd),
    .sts           (sts)
  );

  pfsa_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .request      (request),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cmd          (cmd),
    .sts          (sts)
  );

endmodule

[tb/frame_grant_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_grant_checker
// Watches the register port and both item channels of the page frame stack
// allocator, predicts each result from its own copy of the free stack, the
// allocated bitmap and the counters, and compares every result field by field.
// ----------------------------------------------------------------------------
module frame_grant_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [pfsa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pfsa_pkg::FRAME_W-1:0]    cfg_data,
  input  logic                            request_valid,
  input  logic                            request_stall,
  input  pfsa_pkg::request_t              request,
  input  logic                            result_valid,
  input  logic                            result_stall,
  input  pfsa_pkg::result_t               result,
  output int                              failures,
  output int                              pending,
  output logic [pfsa_pkg::CNT_W-1:0]      pool_taken,
  output logic [pfsa_pkg::CNT_W-1:0]      pool_peak
);
  import pfsa_pkg::*;

  localparam int PRINT_LIMIT = 40;

  logic [FRAME_W-1:0] map_first;
  logic [CNT_W-1:0]   map_size;
  logic [FRAME_W-1:0] pool_first;
  logic [CNT_W-1:0]   pool_size;
  logic [FRAME_W-1:0] dma_first;

  logic [FRAME_W-1:0] stack_mem [MAX_FRAMES];
  logic               frame_marked [MAX_FRAMES];
  logic [DMA_W-1:0]   dma_used;
  result_t            expected_grants [$];

  function automatic logic [CNT_W-1:0] clamp_frames(input logic [CNT_W-1:0] v);
    return (v > MAX_FRAMES) ? CNT_W'(MAX_FRAMES) : v;
  endfunction

  function automatic logic in_map(input logic [FRAME_W-1:0] f);
    logic [FRAME_W-1:0] offset;
    offset = f - map_first;
    return (f >= map_first) && (offset < clamp_frames(map_size));
  endfunction

  function automatic logic [IDX_W-1:0] map_slot(input logic [FRAME_W-1:0] f);
    logic [FRAME_W-1:0] offset;
    offset = f - map_first;
    return offset[IDX_W-1:0];
  endfunction

  function automatic result_t grant_for(input request_t req);
    result_t            r;
    logic [CNT_W-1:0]   cap;
    logic [CNT_W-1:0]   depth;
    logic [CNT_W-1:0]   lazy_bound;
    logic [CNT_W-1:0]   pos;
    logic [FRAME_W-1:0] pos_frame;
    logic [FRAME_W-1:0] f;
    logic [DMA_W-1:0]   room;
    r = '0;
    cap = clamp_frames(pool_size);
    depth = (pool_taken <= cap) ? cap - pool_taken : '0;
    case (req.kind)
      KIND_ALLOC: begin
        if (depth == 0) begin
          r.status = ST_EMPTY;
        end else begin
          pos = depth - 1'b1;
          pos_frame = FRAME_W'(pos);
          lazy_bound = (pool_peak <= cap) ? cap - pool_peak : '0;
          f = (pos < lazy_bound) ? pool_first + pos_frame : stack_mem[pos[IDX_W-1:0]];
          pool_taken = pool_taken + 1'b1;
          if (pool_taken > pool_peak) pool_peak = pool_taken;
          if (!in_map(f)) begin
            r.status = ST_OUTSIDE;
          end else if (frame_marked[map_slot(f)]) begin
            r.status = ST_ALREADY;
          end else begin
            frame_marked[map_slot(f)] = 1'b1;
            r.frame_out = f;
          end
        end
      end
      KIND_FREE: begin
        if (depth >= cap) begin
          r.status = ST_FULL;
        end else if (!in_map(req.frame)) begin
          r.status = ST_OUTSIDE;
        end else if (!frame_marked[map_slot(req.frame)]) begin
          r.status = ST_NOT_ALLOC;
        end else begin
          frame_marked[map_slot(req.frame)] = 1'b0;
          stack_mem[depth[IDX_W-1:0]] = req.frame;
          pool_taken = pool_taken - 1'b1;
        end
      end
      KIND_DMA: begin
        room = (dma_used <= DMA_FRAMES) ? DMA_W'(DMA_FRAMES) - dma_used : '0;
        if (req.dma_pages == 0 || req.dma_pages > room) begin
          r.status = ST_DMA_REFUSED;
        end else begin
          f = dma_first + FRAME_W'(dma_used);
          if (!in_map(f)) begin
            r.status = ST_OUTSIDE;
          end else if (frame_marked[map_slot(f)]) begin
            r.status = ST_ALREADY;
          end else begin
            frame_marked[map_slot(f)] = 1'b1;
            dma_used = dma_used + req.dma_pages;
            r.frame_out = f;
          end
        end
      end
      default: ;
    endcase
    r.allocated_count = pool_taken;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    failures++;
    if (failures <= PRINT_LIMIT)
      $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      map_first = '0;
      map_size = CNT_W'(MAX_FRAMES);
      pool_first = '0;
      pool_size = '0;
      dma_first = '0;
      pool_taken = '0;
      pool_peak = '0;
      dma_used = '0;
      failures = 0;
      foreach (frame_marked[i]) frame_marked[i] = 1'b0;
      expected_grants.delete();
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_grants.size() == 0) begin
          report_mismatch("result with no request waiting", 64'(result), '0);
        end else begin
          want = expected_grants.pop_front();
          if (result.status !== want.status)
            report_mismatch("status", 64'(result.status), 64'(want.status));
          if (result.frame_out !== want.frame_out)
            report_mismatch("frame_out", 64'(result.frame_out), 64'(want.frame_out));
          if (result.allocated_count !== want.allocated_count)
            report_mismatch("allocated_count", 64'(result.allocated_count),
                            64'(want.allocated_count));
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          CFG_MAP_FIRST:   map_first = cfg_data;
          CFG_MAP_FRAMES:  map_size = cfg_data[CNT_W-1:0];
          CFG_POOL_FIRST:  pool_first = cfg_data;
          CFG_POOL_FRAMES: pool_size = cfg_data[CNT_W-1:0];
          CFG_DMA_FIRST:   dma_first = cfg_data;
          default: ;
        endcase
      end
      if (request_valid && !request_stall)
        expected_grants.push_back(grant_for(request));
    end
    pending = expected_grants.size();
  end

endmodule

[tb/tb_page_frame_stack_allocator.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_page_frame_stack_allocator
// Drives allocate, free and DMA requests through several register settings,
// directed corner items first and random items after, with sender gaps and
// receiver stalls; a checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module tb_page_frame_stack_allocator;
  import pfsa_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 600000;

  typedef enum logic [1:0] {
    FLOW_STEADY,
    FLOW_SENDER_GAPS,
    FLOW_RECEIVER_STALLS,
    FLOW_BOTH
  } flow_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [FRAME_W-1:0]   cfg_data = '0;
  logic                 request_valid = 1'b0;
  logic                 request_stall;
  request_t             request = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  result_t              result;

  int               failures;
  int               pending;
  logic [CNT_W-1:0] pool_taken;
  logic [CNT_W-1:0] pool_peak;

  int               gap_pct = 0;
  int               stall_pct = 0;
  int               cycles = 0;
  logic [FRAME_W-1:0] pool_base = '0;
  logic [CNT_W-1:0]   pool_frames_set = '0;
  logic [FRAME_W-1:0] dma_base = '0;

  page_frame_stack_allocator uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .request_valid (request_valid),
    .request_stall (request_stall),
    .request       (request),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result        (result)
  );

  frame_grant_checker grant_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .request_valid (request_valid),
    .request_stall (request_stall),
    .request       (request),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result        (result),
    .failures      (failures),
    .pending       (pending),
    .pool_taken    (pool_taken),
    .pool_peak     (pool_peak)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    result_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic set_flow(input flow_t mode);
    case (mode)
      FLOW_STEADY: begin
        gap_pct = 0;
        stall_pct = 0;
      end
      FLOW_SENDER_GAPS: begin
        gap_pct = 79;
        stall_pct = 0;
      end
      FLOW_RECEIVER_STALLS: begin
        gap_pct = 0;
        stall_pct = 79;
      end
      default: begin
        gap_pct = 36;
        stall_pct = 36;
      end
    endcase
  endtask

  function automatic request_t make_item(input logic [KIND_W-1:0] kind,
                                         input logic [FRAME_W-1:0] frame,
                                         input logic [PAGES_W-1:0] pages);
    request_t item;
    item.kind = kind;
    item.frame = frame;
    item.dma_pages = pages;
    return item;
  endfunction

  function automatic request_t random_item();
    request_t           item;
    logic [31:0]        noise;
    logic [31:0]        offset;
    logic [FRAME_W-1:0] near;
    int unsigned        pick;
    int unsigned        span;
    noise = $urandom;
    item.frame = noise[FRAME_W-1:0];
    item.dma_pages = noise[31:26];
    pick = $urandom_range(99);
    if (pick < 40) item.kind = KIND_ALLOC;
    else if (pick < 80) item.kind = KIND_FREE;
    else if (pick < 96) item.kind = KIND_DMA;
    else item.kind = KIND_UNUSED;
    if (item.kind == KIND_DMA && $urandom_range(1) == 0) begin
      offset = $urandom_range(4, 1);
      item.dma_pages = offset[PAGES_W-1:0];
    end
    if (item.kind == KIND_FREE) begin
      pick = $urandom_range(99);
      span = (pool_frames_set > 64) ? 64 : int'(pool_frames_set);
      if (pick < 55 && span != 0) begin
        near = pool_base + FRAME_W'(pool_frames_set) - 1'b1;
        offset = $urandom_range(span - 1);
        item.frame = near - offset[FRAME_W-1:0];
      end else if (pick < 70) begin
        offset = $urandom_range(63);
        item.frame = dma_base + offset[FRAME_W-1:0];
      end
    end
    return item;
  endfunction

  task automatic send_item(input request_t item);
    while ($urandom_range(99) < gap_pct) begin
      request_valid <= 1'b0;
      @(posedge clk);
    end
    request <= item;
    request_valid <= 1'b1;
    @(posedge clk);
    while (request_stall) @(posedge clk);
  endtask

  task automatic wait_idle();
    request_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [FRAME_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
  endtask

  // Raise the taken count to its peak before resizing the pool, so that the
  // resized stack holds only its ascending initial frames or pushed ones.
  task automatic configure(input logic [FRAME_W-1:0] map_first,
                           input logic [CNT_W-1:0]   map_size,
                           input logic [FRAME_W-1:0] pool_first,
                           input logic [CNT_W-1:0]   pool_size,
                           input logic [FRAME_W-1:0] dma_first);
    request_t item;
    item = make_item(KIND_ALLOC, '0, '0);
    wait_idle();
    if (pool_size != pool_frames_set && pool_peak != pool_taken) begin
      repeat (pool_peak - pool_taken) send_item(item);
      wait_idle();
    end
    write_reg(CFG_MAP_FIRST, map_first);
    write_reg(CFG_MAP_FRAMES, FRAME_W'(map_size));
    write_reg(CFG_POOL_FIRST, pool_first);
    write_reg(CFG_POOL_FRAMES, FRAME_W'(pool_size));
    write_reg(CFG_DMA_FIRST, dma_first);
    cfg_write <= 1'b0;
    pool_base = pool_first;
    pool_frames_set = pool_size;
    dma_base = dma_first;
  endtask

  task automatic run_random(input int count);
    for (int q = 0; q < 4; q++) begin
      set_flow(flow_t'(q));
      repeat (count / 4) send_item(random_item());
    end
    set_flow(FLOW_STEADY);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    set_flow(FLOW_STEADY);

    send_item(make_item(KIND_ALLOC, '0, '0));
    send_item(make_item(KIND_FREE, '0, '0));
    send_item(make_item(KIND_DMA, '1, '0));
    send_item(make_item(KIND_DMA, '0, 6'd33));
    send_item(make_item(KIND_UNUSED, '1, '1));
    send_item(make_item(KIND_DMA, '0, 6'd1));
    send_item(make_item(KIND_DMA, '0, '1));

    configure(20'h00100, 17'd64, 20'h00100, 17'd6, 20'h00100);
    send_item(make_item(KIND_ALLOC, '1, '1));
    send_item(make_item(KIND_DMA, '0, 6'd2));
    send_item(make_item(KIND_FREE, 20'h00105, '0));
    send_item(make_item(KIND_FREE, 20'h00105, '0));
    send_item(make_item(KIND_FREE, 20'h000FF, '0));
    send_item(make_item(KIND_FREE, 20'h00140, '0));
    send_item(make_item(KIND_FREE, 20'h00101, '0));
    repeat (6) send_item(make_item(KIND_ALLOC, '0, '0));
    send_item(make_item(KIND_ALLOC, '0, '0));
    send_item(make_item(KIND_DMA, '0, 6'd1));
    run_random(112);

    configure(20'hFFFC0, 17'd48, 20'hFFFE0, 17'd40, 20'h00000);
    send_item(make_item(KIND_DMA, '0, 6'd1));
    send_item(make_item(KIND_ALLOC, '0, '0));
    run_random(112);

    configure(20'h00000, 17'd65536, 20'h00800, 17'd65536, 20'hFFFFF);
    run_random(180);

    configure(20'hFFFFF, 17'd0, 20'hFFFFF, 17'd65536, 20'h80000);
    run_random(24);

    configure(20'h12345, 17'd1, 20'hFFFFF, 17'd0, 20'h12345);
    run_random(24);

    wait_idle();
    if (failures == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/pfsa_pkg.sv
hdl/pfsa_ctrl.sv
hdl/pfsa_dp.sv
hdl/page_frame_stack_allocator.sv
tb/frame_grant_checker.sv
tb/tb_page_frame_stack_allocator.sv
